// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the state-space step core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, ignored while reset is asserted
`define SSA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every rising edge, including during reset
`define SSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ssstep_pkg.sv =====
// ----------------------------------------------------------------------------
// ssstep_pkg
// Constants and register index codes for the state-space step core.
// ----------------------------------------------------------------------------
`default_nettype none

package ssstep_pkg;

	// model order: three states
	localparam int unsigned NUM_STATES = 3;

	// register index port width
	localparam int unsigned REG_IDX_W = 3;

	// configuration register map
	typedef enum logic [REG_IDX_W-1:0] {
		REG_COEF_ROW_ONE     = 3'd0,
		REG_COEF_ROW_TWO     = 3'd1,
		REG_COEF_ROW_THREE   = 3'd2,
		REG_INPUT_GAINS      = 3'd3,
		REG_OUTPUT_GAIN      = 3'd4,
		REG_FEEDTHROUGH_GAIN = 3'd5,
		REG_START_STATE      = 3'd6
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== src/ssstep_if.sv =====
// ----------------------------------------------------------------------------
// ssstep_if
// Valid/ready channels for input samples and model results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssstep_in_if #(
	parameter int DATA_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] sample_in;
	logic                         restart;

	modport source (output valid, output sample_in, output restart, input ready);
	modport sink   (input valid, input sample_in, input restart, output ready);
endinterface

interface ssstep_out_if #(
	parameter int DATA_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] sample_out;
	logic                         saturated;

	modport source (output valid, output sample_out, output saturated, input ready);
	modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

`default_nettype wire

// ===== src/third_order_state_space_step_core.sv =====
// ----------------------------------------------------------------------------
// third_order_state_space_step_core
// One step of a third-order discrete state-space model per input beat.
// ----------------------------------------------------------------------------
// An accepted input beat goes through the input register, then the result register,
// which presents it as the result beat.
// Throughput: one beat per cycle unless a waiting result stalls it; the state update
// closes its loop through the four-term multiply-add and round/saturate of each row.
// Reset: state, previous input, config registers and valid flags clear to zero at once.
// While a result waits downstream the input register holds one more beat,
// then input stalls until the result is taken.
`default_nettype none

module third_order_state_space_step_core #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 12
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	ssstep_in_if.sink                                         din,
	ssstep_out_if.source                                      dout,
	input  wire logic                                         cfg_wr_en,
	input  wire logic [ssstep_pkg::REG_IDX_W-1:0]             cfg_index,
	input  wire logic [ssstep_pkg::NUM_STATES*DATA_WIDTH-1:0] cfg_data
);

	`include "assert_macros.svh"

	localparam int NS = ssstep_pkg::NUM_STATES;

	logic signed [DATA_WIDTH-1:0] a_mat [NS][NS];
	logic signed [DATA_WIDTH-1:0] b_vec [NS];
	logic signed [DATA_WIDTH-1:0] c_gain;
	logic signed [DATA_WIDTH-1:0] d_gain;
	logic signed [DATA_WIDTH-1:0] x_init [NS];

	logic                         valid_s1;
	logic signed [DATA_WIDTH-1:0] sample_s1;
	logic                         restart_s1;

	logic signed [DATA_WIDTH-1:0] x_q [NS];
	logic signed [DATA_WIDTH-1:0] u_prev_q;

	logic                         out_valid_q;
	logic signed [DATA_WIDTH-1:0] y_q;
	logic                         sat_q;

	logic                         adv;
	logic signed [DATA_WIDTH-1:0] x_cur [NS];
	logic signed [DATA_WIDTH-1:0] u_cur;
	logic signed [DATA_WIDTH-1:0] x_next [NS];
	logic                         row_sat [NS];
	logic signed [DATA_WIDTH-1:0] y_next;
	logic                         y_sat;
	logic signed [DATA_WIDTH-1:0] out_a [2];
	logic signed [DATA_WIDTH-1:0] out_b [2];

	// configuration registers
	ssstep_cfg_regs #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.a_mat  (a_mat),
		.b_vec  (b_vec),
		.c_gain (c_gain),
		.d_gain (d_gain),
		.x_init (x_init)
	);

	// stage 1 moves on when the result register is free or being emptied
	assign adv       = valid_s1 && (!out_valid_q || dout.ready);
	assign din.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			sample_s1  <= din.sample_in;
			restart_s1 <= din.restart;
		end
	end

	// restart swaps in the start state and a zero previous input
	always_comb begin
		for (int k = 0; k < NS; k++) begin
			x_cur[k] = restart_s1 ? x_init[k] : x_q[k];
		end
		u_cur = restart_s1 ? '0 : u_prev_q;
	end

	// new state rows: x' = A*x + B*u
	for (genvar r = 0; r < NS; r++) begin : g_row
		logic signed [DATA_WIDTH-1:0] op_a [NS+1];
		logic signed [DATA_WIDTH-1:0] op_b [NS+1];

		always_comb begin
			for (int k = 0; k < NS; k++) begin
				op_a[k] = x_cur[k];
				op_b[k] = a_mat[r][k];
			end
			op_a[NS] = sample_s1;
			op_b[NS] = b_vec[r];
		end

		ssstep_mac #(
			.DATA_WIDTH (DATA_WIDTH),
			.FRAC_BITS  (FRAC_BITS),
			.NUM_TERMS  (NS + 1)
		) u_mac (
			.op_a   (op_a),
			.op_b   (op_b),
			.result (x_next[r]),
			.sat    (row_sat[r])
		);
	end

	// output: y = c3*x3 + d*u_prev, from the state before the update
	assign out_a[0] = x_cur[NS-1];
	assign out_b[0] = c_gain;
	assign out_a[1] = u_cur;
	assign out_b[1] = d_gain;

	ssstep_mac #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.NUM_TERMS  (2)
	) u_out_mac (
		.op_a   (out_a),
		.op_b   (out_b),
		.result (y_next),
		.sat    (y_sat)
	);

	// model state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) begin
				x_q[k] <= '0;
			end
			u_prev_q <= '0;
		end else if (adv) begin
			for (int k = 0; k < NS; k++) begin
				x_q[k] <= x_next[k];
			end
			u_prev_q <= sample_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_q   <= y_next;
			sat_q <= y_sat || row_sat[0] || row_sat[1] || row_sat[2];
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.sample_out = y_q;
	assign dout.saturated  = sat_q;

	// checks
	`SSA_ASSERT(a_empty_ready, clk, arst_n, !valid_s1 |-> din.ready, "stage 1 empty but not ready")
	`SSA_ASSERT(a_stall_block, clk, arst_n, (valid_s1 && !adv) |-> !din.ready, "beat taken over a stalled item")
	`SSA_ASSERT(a_adv_result, clk, arst_n, adv |=> dout.valid, "advanced item did not reach result register")
	`SSA_ASSERT(a_state_hold, clk, arst_n, !adv |=> ($stable(x_q[0]) && $stable(x_q[2]) && $stable(u_prev_q)), "state moved without a step")

endmodule

`default_nettype wire

// ===== src/ssstep_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ssstep_cfg_regs
// Configuration register bank; unpacks coefficient fields for the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ssstep_cfg_regs #(
	parameter int DATA_WIDTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   wr_en,
	input  wire logic [ssstep_pkg::REG_IDX_W-1:0]       index,
	input  wire logic [ssstep_pkg::NUM_STATES*DATA_WIDTH-1:0] data,
	output logic signed [DATA_WIDTH-1:0] a_mat [ssstep_pkg::NUM_STATES][ssstep_pkg::NUM_STATES],
	output logic signed [DATA_WIDTH-1:0] b_vec [ssstep_pkg::NUM_STATES],
	output logic signed [DATA_WIDTH-1:0] c_gain,
	output logic signed [DATA_WIDTH-1:0] d_gain,
	output logic signed [DATA_WIDTH-1:0] x_init [ssstep_pkg::NUM_STATES]
);

	localparam int NS = ssstep_pkg::NUM_STATES;
	localparam int PW = NS * DATA_WIDTH;

	logic [PW-1:0]         rows_q [NS];
	logic [PW-1:0]         gains_q;
	logic [DATA_WIDTH-1:0] c_q;
	logic [DATA_WIDTH-1:0] d_q;
	logic [PW-1:0]         init_q;

	// register writes; indexes beyond the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NS; r++) begin
				rows_q[r] <= '0;
			end
			gains_q <= '0;
			c_q     <= '0;
			d_q     <= '0;
			init_q  <= '0;
		end else if (wr_en) begin
			unique case (index)
				ssstep_pkg::REG_COEF_ROW_ONE:     rows_q[0] <= data;
				ssstep_pkg::REG_COEF_ROW_TWO:     rows_q[1] <= data;
				ssstep_pkg::REG_COEF_ROW_THREE:   rows_q[2] <= data;
				ssstep_pkg::REG_INPUT_GAINS:      gains_q   <= data;
				ssstep_pkg::REG_OUTPUT_GAIN:      c_q       <= data[DATA_WIDTH-1:0];
				ssstep_pkg::REG_FEEDTHROUGH_GAIN: d_q       <= data[DATA_WIDTH-1:0];
				ssstep_pkg::REG_START_STATE:      init_q    <= data;
				default: begin
				end
			endcase
		end
	end

	// field unpacking: element 0 in the low bits
	always_comb begin
		for (int r = 0; r < NS; r++) begin
			for (int k = 0; k < NS; k++) begin
				a_mat[r][k] = $signed(rows_q[r][k*DATA_WIDTH +: DATA_WIDTH]);
			end
			b_vec[r]  = $signed(gains_q[r*DATA_WIDTH +: DATA_WIDTH]);
			x_init[r] = $signed(init_q[r*DATA_WIDTH +: DATA_WIDTH]);
		end
	end

	assign c_gain = $signed(c_q);
	assign d_gain = $signed(d_q);

endmodule

`default_nettype wire

// ===== src/ssstep_mac.sv =====
// ----------------------------------------------------------------------------
// ssstep_mac
// Sum of signed products, rounded half up and saturated to the data width.
// ----------------------------------------------------------------------------
`default_nettype none

module ssstep_mac #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 12,
	parameter int NUM_TERMS  = 4
) (
	input  wire logic signed [DATA_WIDTH-1:0] op_a [NUM_TERMS],
	input  wire logic signed [DATA_WIDTH-1:0] op_b [NUM_TERMS],
	output logic signed [DATA_WIDTH-1:0]      result,
	output logic                              sat
);

	// room for four full products plus the rounding constant
	localparam int PW = 2 * DATA_WIDTH;
	localparam int SW = 2 * DATA_WIDTH + 3;

	localparam logic signed [SW-1:0] HALF =
		$signed({{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1));
	localparam logic signed [SW-1:0] HI =
		$signed({{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
	localparam logic signed [SW-1:0] LO = ~HI;

	logic signed [PW-1:0] prod [NUM_TERMS];
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] rnd;

	// exact products and their sum
	always_comb begin
		sum = '0;
		for (int i = 0; i < NUM_TERMS; i++) begin
			prod[i] = op_a[i] * op_b[i];
			sum     = sum + SW'(prod[i]);
		end
	end

	// round half toward plus infinity, then clamp
	assign rnd = (sum + HALF) >>> FRAC_BITS;

	always_comb begin
		priority if (rnd > HI) begin
			result = HI[DATA_WIDTH-1:0];
			sat    = 1'b1;
		end else if (rnd < LO) begin
			result = LO[DATA_WIDTH-1:0];
			sat    = 1'b1;
		end else begin
			result = rnd[DATA_WIDTH-1:0];
			sat    = 1'b0;
		end
	end

endmodule

`default_nettype wire
